>>> hw/rtl/pwsa_pkg.sv
// Package for the pixel Welford split accumulator.
// Types, constants and command/status structs shared by the controller, datapath and top level.
package pwsa_pkg;

    localparam int MAX_PIXELS_DEF = 4096;
    localparam int CHANNELS_DEF   = 16;
    localparam int MAX_SPP_DEF    = 1024;

    localparam int NUM_BUFFERS = 2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SPP    = 2'd2;

    localparam logic [12:0] WIDTH_RST  = 13'd64;
    localparam logic [12:0] HEIGHT_RST = 13'd64;
    localparam logic [10:0] SPP_RST    = 11'd8;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_LOAD,
        ST_DIV_MEAN,
        ST_WAIT_MEAN,
        ST_PROD,
        ST_DIV_HALF,
        ST_WAIT_HALF,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic check;
        logic read;
        logic load;
        logic div_mean;
        logic prod;
        logic div_half;
        logic write;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic clear_done;
        logic in_range;
        logic div_done;
        logic rem_done;
    } stat_t;

endpackage

>>> hw/rtl/pwsa_divider.sv
// Iterative divider of a signed dividend by an unsigned divisor, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its ports.
module pwsa_divider #(
    parameter int DW = 34,
    parameter int VW = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic        [VW-1:0] divisor,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg, q_next;
    logic [VW:0]   r_reg, r_next;
    logic [VW-1:0] d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   shifted;
    logic [DW-1:0] mag_in;

    always_comb
    begin
        mag_in   = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted  = {r_reg[VW-1:0], q_reg[DW-1]};
        if (start)
        begin
            q_next    = mag_in;
            r_next    = '0;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                r_next = shifted - {1'b0, d_reg};
                q_next = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg   <= divisor;
            neg_reg <= dividend[DW-1];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

>>> hw/rtl/pwsa_datapath.sv
// Datapath: stores, range check, Welford and half-buffer arithmetic.
// Depends on pwsa_pkg and pwsa_divider.
module pwsa_datapath
    import pwsa_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF,
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_SPP    = MAX_SPP_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    output stat_t              stat,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic [11:0]        pixel_x,
    input  logic [11:0]        pixel_y,
    input  logic [9:0]         sample_number,
    input  logic [3:0]         channel,
    input  logic signed [31:0] sample_value,
    output logic               accepted,
    output logic signed [31:0] running_mean,
    output logic signed [63:0] deviation_sum,
    output logic signed [31:0] half_mean,
    output logic               half_select,
    output logic [10:0]        pixel_count
);
    localparam int PW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW  = PW + CHW;
    localparam int SLOTS = MAX_PIXELS * CHANNELS;
    localparam int NW  = $clog2(MAX_SPP + 1);
    localparam int DW  = 34;
    localparam int CLW = (SLOTS > MAX_PIXELS) ? SW : PW;

    logic [12:0] width_reg, height_reg;
    logic [10:0] spp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            spp_reg    <= SPP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data[12:0];
                REG_SPP:    spp_reg    <= cfg_data[10:0];
                default:    ;
            endcase
        end
    end

    logic signed [31:0] mean_mem  [SLOTS];
    logic signed [63:0] dev_mem   [SLOTS];
    logic signed [31:0] half0_mem [SLOTS];
    logic signed [31:0] half1_mem [SLOTS];
    logic [NW-1:0]      cnt_mem   [MAX_PIXELS];

    logic [CLW-1:0] clr_reg;
    logic [CLW:0]   clr_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (ctrl.clear_step)
            clr_reg <= clr_reg + 1'b1;
    end
    assign clr_ext = {1'b0, clr_reg};

    logic [11:0] x_reg, y_reg;
    logic [9:0]  k_reg;
    logic [3:0]  ch_reg;
    logic signed [31:0] v_reg;
    logic [10:0] spp_eff_reg;
    logic [9:0]  half_reg;
    logic        ok_reg;
    logic [24:0] pix_reg;
    logic [PW-1:0] pix_idx;
    logic [SW-1:0] slot_reg;

    logic [10:0] spp_eff;
    logic [24:0] pix_calc;

    always_comb
    begin
        spp_eff  = (32'(spp_reg) > MAX_SPP) ? 11'(MAX_SPP) : spp_reg;
        pix_calc = 25'(x_reg) + 25'(y_reg) * 25'(width_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            x_reg       <= pixel_x;
            y_reg       <= pixel_y;
            k_reg       <= sample_number;
            ch_reg      <= channel;
            v_reg       <= sample_value;
            spp_eff_reg <= spp_eff;
            half_reg    <= (spp_eff[10:1] == 10'd0) ? 10'd1 : spp_eff[10:1];
        end
        if (ctrl.check)
        begin
            pix_reg <= pix_calc;
            ok_reg  <= (13'(x_reg) < width_reg) && (13'(y_reg) < height_reg)
                    && (11'(k_reg) < spp_eff_reg) && (32'(ch_reg) < CHANNELS)
                    && (32'(pix_calc) < MAX_PIXELS);
        end
    end

    assign pix_idx = pix_reg[PW-1:0];
    always_comb
        slot_reg = SW'(pix_reg * 25'(CHANNELS)) + SW'(ch_reg);

    logic signed [31:0] mean_rd, half0_rd, half1_rd;
    logic signed [63:0] dev_rd;
    logic [NW-1:0]      cnt_rd;

    logic [10:0]        n_reg;
    logic               sel_reg;
    logic [9:0]         f_reg;
    logic signed [31:0] hm_old_reg, mean_old_reg;
    logic signed [63:0] dev_old_reg;
    logic signed [31:0] newmean_reg, newhm_reg;
    logic signed [63:0] dev_new_reg;
    logic signed [32:0] delta_reg;

    logic [10:0] n_calc;
    logic [10:0] n_m1;
    logic        sel_calc;
    logic [10:0] rem_calc;

    always_comb
    begin
        n_calc   = ((11'(k_reg) + 11'd1) > 11'(cnt_rd)) ? 11'(k_reg) + 11'd1
                                                        : 11'(cnt_rd);
        n_m1     = n_calc - 11'd1;
        sel_calc = n_m1 >= 11'(half_reg);
        rem_calc = sel_calc ? n_m1 - 11'(half_reg) : n_m1;
        if (rem_calc >= 11'(half_reg))
            rem_calc = rem_calc - 11'(half_reg);
    end

    // quotient of n-1 by half is at most 2 when n fits spp and half>=spp/2,
    // but count may exceed spp after a register change: reduce iteratively
    logic [10:0] rem_reg;
    logic        rem_busy;

    always_ff @(posedge clk)
    begin
        if (ctrl.read)
        begin
            mean_rd  <= mean_mem[slot_reg];
            dev_rd   <= dev_mem[slot_reg];
            half0_rd <= half0_mem[slot_reg];
            half1_rd <= half1_mem[slot_reg];
            cnt_rd   <= cnt_mem[pix_idx];
        end
        if (ctrl.load)
        begin
            n_reg        <= n_calc;
            sel_reg      <= sel_calc;
            rem_reg      <= rem_calc;
            mean_old_reg <= mean_rd;
            dev_old_reg  <= dev_rd;
            hm_old_reg   <= sel_calc ? half1_rd : half0_rd;
            delta_reg    <= 33'(v_reg) - 33'(mean_rd);
        end
        else if (rem_busy)
            rem_reg <= rem_reg - 11'(half_reg);
    end
    assign rem_busy = rem_reg >= 11'(half_reg);
    assign f_reg    = 10'(rem_reg) + 10'd1;

    logic               div_start;
    logic signed [DW-1:0] div_num;
    logic [10:0]        div_den;
    logic               div_done;
    logic signed [DW-1:0] div_q;

    always_comb
    begin
        div_start = ctrl.div_mean || ctrl.div_half;
        if (ctrl.div_half)
        begin
            div_num = DW'(v_reg) - DW'(hm_old_reg);
            div_den = 11'(f_reg);
        end
        else
        begin
            div_num = DW'(delta_reg);
            div_den = n_reg;
        end
    end

    pwsa_divider #(.DW(DW), .VW(11)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    logic signed [33:0] d2_calc;
    logic [32:0]        ma, mb;
    logic [65:0]        prod_full;
    logic [63:0]        prod_sat;
    logic [64:0]        dev_sum;
    logic               neg_calc;

    always_comb
    begin
        d2_calc   = 34'(v_reg) - 34'(newmean_reg);
        ma        = delta_reg[32] ? 33'(-delta_reg) : 33'(delta_reg);
        mb        = d2_calc[33] ? 33'(-d2_calc) : 33'(d2_calc);
        neg_calc  = (delta_reg[32] != d2_calc[33]) || ma == '0 || mb == '0;
        prod_full = 66'(ma) * 66'(mb);
        if (neg_calc)
            prod_sat = '0;
        else if (prod_full > 66'h7FFF_FFFF_FFFF_FFFF)
            prod_sat = 64'h7FFF_FFFF_FFFF_FFFF;
        else
            prod_sat = prod_full[63:0];
    end

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.div_half)
            newmean_reg <= 32'(div_q) + mean_old_reg;
        if (ctrl.prod)
            prod_reg <= prod_sat;
        if (ctrl.write)
            newhm_reg <= 32'(div_q) + hm_old_reg;
    end

    always_comb
    begin
        dev_sum = 65'(dev_old_reg) + 65'(prod_reg);
    end

    // sum is taken the cycle after the product is registered
    logic prod_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_d_reg <= 1'b0;
        else
            prod_d_reg <= ctrl.prod;
    end

    always_ff @(posedge clk)
    begin
        if (prod_d_reg)
            dev_new_reg <= (dev_sum > 65'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                            : dev_sum[63:0];
    end

    logic signed [31:0] hm_wr;
    assign hm_wr = 32'(div_q) + hm_old_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.clear_step)
        begin
            if (clr_ext < (CLW+1)'(SLOTS))
            begin
                mean_mem[SW'(clr_reg)]  <= '0;
                dev_mem[SW'(clr_reg)]   <= '0;
                half0_mem[SW'(clr_reg)] <= '0;
                half1_mem[SW'(clr_reg)] <= '0;
            end
            if (clr_ext < (CLW+1)'(MAX_PIXELS))
                cnt_mem[PW'(clr_reg)] <= '0;
        end
        else if (ctrl.write)
        begin
            mean_mem[slot_reg] <= newmean_reg;
            dev_mem[slot_reg]  <= dev_new_reg;
            if (sel_reg)
                half1_mem[slot_reg] <= hm_wr;
            else
                half0_mem[slot_reg] <= hm_wr;
            cnt_mem[pix_idx] <= NW'(n_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            accepted      <= ok_reg;
            running_mean  <= ok_reg ? newmean_reg : '0;
            deviation_sum <= ok_reg ? dev_new_reg : '0;
            half_mean     <= ok_reg ? newhm_reg : '0;
            half_select   <= ok_reg ? sel_reg : 1'b0;
            pixel_count   <= ok_reg ? n_reg : '0;
        end
    end

    assign stat.clear_done = (clr_ext == (CLW+1)'(((SLOTS > MAX_PIXELS) ? SLOTS : MAX_PIXELS) - 1));
    assign stat.in_range   = ok_reg;
    assign stat.div_done   = div_done;
    assign stat.rem_done   = !rem_busy;

endmodule

>>> hw/rtl/pwsa_controller.sv
// Controller state machine sequencing clear, check, read, divide, product, write and output.
// Depends on pwsa_pkg.
module pwsa_controller
    import pwsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  out_stall,
    output logic  out_valid,
    input  stat_t stat,
    output ctrl_t ctrl
);
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ov_next    = ov_reg && out_stall;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clear_step = 1'b1;
                if (stat.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                ctrl.check = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (stat.in_range)
                begin
                    ctrl.read  = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                    state_next = ST_OUT;
            end
            ST_LOAD:
            begin
                ctrl.load  = 1'b1;
                state_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN:
            begin
                ctrl.div_mean = 1'b1;
                state_next    = ST_WAIT_MEAN;
            end
            ST_WAIT_MEAN:
                if (stat.div_done)
                    state_next = ST_DIV_HALF;
            ST_DIV_HALF:
                if (stat.rem_done)
                begin
                    ctrl.div_half = 1'b1;
                    state_next    = ST_PROD;
                end
            ST_PROD:
            begin
                ctrl.prod  = 1'b1;
                state_next = ST_WAIT_HALF;
            end
            ST_WAIT_HALF:
                if (stat.div_done)
                begin
                    ctrl.write = 1'b1;
                    state_next = ST_WRITE;
                end
            ST_WRITE:
                state_next = ST_OUT;
            ST_OUT:
                if (!ov_reg)
                begin
                    ctrl.out_load = 1'b1;
                    ov_next       = 1'b1;
                    state_next    = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;

endmodule

>>> hw/rtl/pixel_welford_split_accumulator.sv
// Pixel Welford split accumulator, top level. One transaction at a time.
// A new input is taken only after the last result is loaded. Accepted samples
// use the shared bit-serial divider twice; rejected ones skip it. A count far
// above a lowered samples-per-pixel adds an iterative reduction; a held result stalls.
// After reset a clearing pass over all MAX_PIXELS*CHANNELS slots runs before input.
// Reset is asynchronous, active low. Depends on pwsa_pkg and submodules.
module pixel_welford_split_accumulator
    import pwsa_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF,
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_SPP    = MAX_SPP_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        pixel_x,
    input  logic [11:0]        pixel_y,
    input  logic [9:0]         sample_number,
    input  logic [3:0]         channel,
    input  logic signed [31:0] sample_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic signed [31:0] running_mean,
    output logic signed [63:0] deviation_sum,
    output logic signed [31:0] half_mean,
    output logic               half_select,
    output logic [10:0]        pixel_count
);
    ctrl_t ctrl;
    stat_t stat;

    pwsa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    pwsa_datapath #(
        .MAX_PIXELS (MAX_PIXELS),
        .CHANNELS   (CHANNELS),
        .MAX_SPP    (MAX_SPP)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .sample_number (sample_number),
        .channel       (channel),
        .sample_value  (sample_value),
        .accepted      (accepted),
        .running_mean  (running_mean),
        .deviation_sum (deviation_sum),
        .half_mean     (half_mean),
        .half_select   (half_select),
        .pixel_count   (pixel_count)
    );

endmodule
